// File: hw/rtl/lseg_pkg.sv
// lseg_pkg: shared constants, codes and structs of the led strip effect generator
// no dependencies; imported by every module of the block
`default_nettype none

package lseg_pkg;

    localparam int LED_TOTAL = 18;
    localparam int LED_W     = 5;
    localparam int HUE_SPAN  = 60 * LED_TOTAL;
    localparam int HUE_STEP  = 360;
    localparam int HUE_TURNS = 360;

    localparam logic [7:0] TIMING_BYTE = 8'hAA;

    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_SOLID   = 3'd1;
    localparam logic [2:0] MODE_FLASH   = 3'd2;
    localparam logic [2:0] MODE_CHASE   = 3'd3;
    localparam logic [2:0] MODE_RAINBOW = 3'd4;
    localparam logic [2:0] MODE_TIMING  = 3'd5;

    localparam logic [2:0] REG_MODE          = 3'd0;
    localparam logic [2:0] REG_RED           = 3'd1;
    localparam logic [2:0] REG_GREEN         = 3'd2;
    localparam logic [2:0] REG_BLUE          = 3'd3;
    localparam logic [2:0] REG_CHASE_WIDTH   = 3'd4;
    localparam logic [2:0] REG_FLASH_COUNT   = 3'd5;
    localparam logic [2:0] REG_RAINBOW_LEVEL = 3'd6;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [4:0]  chase_width;
        logic [19:0] flash_count;
        logic [7:0]  rainbow_level;
    } cfg_t;

    // request to the shared multiply-divide unit: floor(a * b / d)
    typedef struct packed {
        logic        start;
        logic [7:0]  a;
        logic [10:0] b;
        logic [10:0] d;
    } mdu_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [7:0]  quo;
        logic [10:0] rem;
    } mdu_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/lseg_cfg_regs.sv
// lseg_cfg_regs: configuration register file of the led strip effect generator
// depends on lseg_pkg
`default_nettype none

module lseg_cfg_regs
    import lseg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [19:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_addr)
                REG_MODE:          cfg_next.mode          = cfg_data[2:0];
                REG_RED:           cfg_next.red           = cfg_data[7:0];
                REG_GREEN:         cfg_next.green         = cfg_data[7:0];
                REG_BLUE:          cfg_next.blue          = cfg_data[7:0];
                REG_CHASE_WIDTH:   cfg_next.chase_width   = cfg_data[4:0];
                REG_FLASH_COUNT:   cfg_next.flash_count   = cfg_data;
                REG_RAINBOW_LEVEL: cfg_next.rainbow_level = cfg_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= MODE_OFF;
            cfg_reg.red           <= 8'd48;
            cfg_reg.green         <= 8'd48;
            cfg_reg.blue          <= 8'd48;
            cfg_reg.chase_width   <= 5'd3;
            cfg_reg.flash_count   <= 20'd0;
            cfg_reg.rainbow_level <= 8'd63;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lseg_mdu.sv
// lseg_mdu: shared multiply then restoring divide, floor(a * b / d), one quotient bit a cycle
// depends on lseg_pkg; the quotient must fit in 8 bits (a * b < 256 * d)
`default_nettype none

module lseg_mdu
    import lseg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  mdu_req_t  req,
    output mdu_rsp_t  rsp
);

    typedef enum logic {U_IDLE, U_RUN} ustate_t;

    ustate_t     state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [10:0] rem_reg, rem_next;
    logic [7:0]  quo_reg, quo_next;
    logic [10:0] div_reg, div_next;
    logic        done_reg, done_next;

    logic [18:0] prod;
    logic [11:0] shifted;
    logic [11:0] trial;
    logic        fits;

    assign prod    = 19'(req.a) * 19'(req.b);
    assign shifted = {rem_reg, quo_reg[7]};
    assign trial   = shifted - {1'b0, div_reg};
    assign fits    = shifted >= {1'b0, div_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    rem_next   = prod[18:8];
                    quo_next   = prod[7:0];
                    div_next   = req.d;
                    cnt_next   = 3'd7;
                    state_next = U_RUN;
                end
            end
            U_RUN:
            begin
                rem_next = fits ? trial[10:0] : shifted[10:0];
                quo_next = {quo_reg[6:0], fits};
                cnt_next = cnt_reg - 3'd1;
                if (cnt_reg == 3'd0)
                begin
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
            end
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= 3'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign rsp.busy = (state_reg == U_RUN);
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// File: hw/rtl/led_strip_effect_generator.sv
// led_strip_effect_generator: frame sequencer, animation state and output register
// depends on lseg_pkg, lseg_cfg_regs and lseg_mdu
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tdata: restart, stop
//  m_*       out  m_tvalid/m_tready   tdata: led_index, green, red, blue; tlast; tuser: finished
//  cfg_*     in   cfg_valid/cfg_ready cfg_addr register index, cfg_data value
//
//  one frame tick gives 18 led transactions; s_tready is low until the last one is built
//  flat leds skip the shared unit; a lit chase led runs it once per colour, a rainbow led twice
//  each pass of the shared unit is 8 quotient steps and then a done strobe
//  the longest frame is a full-width chase
//  reset sets the configuration registers to their defaults and clears all animation counters
//  a stalled m_tready holds the output register and the sequencer waits behind it
`default_nettype none

module led_strip_effect_generator
    import lseg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // restart, stop
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // led_index, green_out, red_out, blue_out
    output logic             m_tlast,
    output logic             m_tuser,   // finished
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [19:0] cfg_data
);

    typedef enum logic [2:0] {ST_IDLE, ST_SETUP, ST_SECT, ST_LED, ST_WAIT, ST_EMIT} state_t;
    typedef enum logic [1:0] {K_FLAT, K_CHASE, K_RAINBOW} kind_t;

    cfg_t     cfg;
    mdu_req_t req;
    mdu_rsp_t rsp;

    lseg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lseg_mdu u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    state_t             state_reg, state_next;
    kind_t              kind_reg, kind_next;
    logic [LED_W-1:0]   led_reg, led_next;
    logic [1:0]         ch_reg, ch_next;
    logic               fin_reg, fin_next;
    logic [7:0]         col_r_reg, col_r_next;
    logic [7:0]         col_g_reg, col_g_next;
    logic [7:0]         col_b_reg, col_b_next;
    logic [LED_W-1:0]   p_reg, p_next;
    logic [4:0]         wc_reg, wc_next;
    logic [4:0]         num_reg, num_next;
    logic [2:0]         sec_reg, sec_next;
    logic [10:0]        hrem_reg, hrem_next;
    logic [7:0]         t_reg, t_next;
    logic [LED_W-1:0]   chase_position_reg, chase_position_next;
    logic [8:0]         hue_phase_reg, hue_phase_next;
    logic [20:0]        flash_ticks_reg, flash_ticks_next;
    logic               halted_reg, halted_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;
    logic               out_fin_reg, out_fin_next;

    logic [LED_W-1:0]   j_val;
    logic               flash_done;
    logic [10:0]        hrem_step;
    logic [7:0]         lvl;

    assign j_val = (p_reg >= led_reg) ? p_reg - led_reg
                                      : LED_W'(LED_TOTAL) - led_reg + p_reg;
    assign flash_done = (cfg.flash_count != 20'd0) &&
                        (flash_ticks_reg >= {cfg.flash_count, 1'b0});
    assign hrem_step  = hrem_reg + 11'(HUE_STEP);
    assign lvl        = cfg.rainbow_level;

    always_comb
    begin
        state_next          = state_reg;
        kind_next           = kind_reg;
        led_next            = led_reg;
        ch_next             = ch_reg;
        fin_next            = fin_reg;
        col_r_next          = col_r_reg;
        col_g_next          = col_g_reg;
        col_b_next          = col_b_reg;
        p_next              = p_reg;
        wc_next             = wc_reg;
        num_next            = num_reg;
        sec_next            = sec_reg;
        hrem_next           = hrem_reg;
        t_next              = t_reg;
        chase_position_next = chase_position_reg;
        hue_phase_next      = hue_phase_reg;
        flash_ticks_next    = flash_ticks_reg;
        halted_next         = halted_reg;
        out_valid_next      = out_valid_reg && !m_tready;
        out_data_next       = out_data_reg;
        out_last_next       = out_last_reg;
        out_fin_next        = out_fin_reg;
        req                 = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tdata[0])
                    begin
                        chase_position_next = '0;
                        hue_phase_next      = '0;
                        flash_ticks_next    = '0;
                        halted_next         = 1'b0;
                    end
                    if (s_tdata[1])
                    begin
                        halted_next = 1'b1;
                    end
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                kind_next  = K_FLAT;
                fin_next   = 1'b0;
                col_r_next = 8'd0;
                col_g_next = 8'd0;
                col_b_next = 8'd0;
                led_next   = '0;
                ch_next    = 2'd0;
                state_next = ST_LED;
                if (halted_reg)
                begin
                    fin_next = 1'b1;
                end
                else
                begin
                    unique case (cfg.mode)
                        MODE_SOLID:
                        begin
                            col_r_next = cfg.red;
                            col_g_next = cfg.green;
                            col_b_next = cfg.blue;
                        end
                        MODE_TIMING:
                        begin
                            col_r_next = TIMING_BYTE;
                            col_g_next = TIMING_BYTE;
                            col_b_next = TIMING_BYTE;
                        end
                        MODE_FLASH:
                        begin
                            if (flash_done)
                            begin
                                fin_next = 1'b1;
                            end
                            else
                            begin
                                if (!flash_ticks_reg[0])
                                begin
                                    col_r_next = cfg.red;
                                    col_g_next = cfg.green;
                                    col_b_next = cfg.blue;
                                end
                                flash_ticks_next = flash_ticks_reg + 21'd1;
                            end
                        end
                        MODE_CHASE:
                        begin
                            kind_next = K_CHASE;
                            p_next    = chase_position_reg;
                            wc_next   = (cfg.chase_width > 5'(LED_TOTAL)) ? 5'(LED_TOTAL)
                                                                          : cfg.chase_width;
                            chase_position_next =
                                (chase_position_reg == LED_W'(LED_TOTAL - 1)) ? '0
                                : chase_position_reg + LED_W'(1);
                        end
                        MODE_RAINBOW:
                        begin
                            kind_next  = K_RAINBOW;
                            req.start  = 1'b1;
                            req.a      = 8'(LED_TOTAL);
                            req.b      = {2'b00, hue_phase_reg};
                            req.d      = 11'(HUE_SPAN);
                            state_next = ST_SECT;
                            hue_phase_next = (hue_phase_reg == 9'(HUE_TURNS - 1)) ? 9'd0
                                             : hue_phase_reg + 9'd1;
                        end
                        default:
                        begin
                            kind_next = K_FLAT;
                        end
                    endcase
                end
            end
            ST_SECT:
            begin
                if (rsp.done)
                begin
                    sec_next   = rsp.quo[2:0];
                    hrem_next  = rsp.rem;
                    state_next = ST_LED;
                end
            end
            ST_LED:
            begin
                ch_next = 2'd0;
                unique case (kind_reg)
                    K_CHASE:
                    begin
                        if (j_val < wc_reg)
                        begin
                            num_next   = wc_reg + 5'd1 - j_val;
                            req.start  = 1'b1;
                            req.a      = cfg.red;
                            req.b      = 11'(wc_reg + 5'd1 - j_val);
                            req.d      = 11'(wc_reg + 5'd1);
                            state_next = ST_WAIT;
                        end
                        else
                        begin
                            col_r_next = 8'd0;
                            col_g_next = 8'd0;
                            col_b_next = 8'd0;
                            state_next = ST_EMIT;
                        end
                    end
                    K_RAINBOW:
                    begin
                        req.start  = 1'b1;
                        req.a      = lvl;
                        req.b      = hrem_reg;
                        req.d      = 11'(HUE_SPAN);
                        state_next = ST_WAIT;
                    end
                    default:
                    begin
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_WAIT:
            begin
                if (rsp.done)
                begin
                    ch_next = ch_reg + 2'd1;
                    if (kind_reg == K_CHASE)
                    begin
                        req.b = 11'(num_reg);
                        req.d = 11'(wc_reg + 5'd1);
                        case (ch_reg)
                            2'd0:
                            begin
                                col_r_next = rsp.quo;
                                req.start  = 1'b1;
                                req.a      = cfg.green;
                            end
                            2'd1:
                            begin
                                col_g_next = rsp.quo;
                                req.start  = 1'b1;
                                req.a      = cfg.blue;
                            end
                            default:
                            begin
                                col_b_next = rsp.quo;
                                state_next = ST_EMIT;
                            end
                        endcase
                    end
                    else if (ch_reg == 2'd0)
                    begin
                        t_next    = rsp.quo;
                        req.start = 1'b1;
                        req.a     = lvl;
                        req.b     = 11'(HUE_SPAN) - hrem_reg;
                        req.d     = 11'(HUE_SPAN);
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                        case (sec_reg)
                            3'd0:
                            begin
                                col_r_next = lvl;     col_g_next = t_reg;   col_b_next = 8'd0;
                            end
                            3'd1:
                            begin
                                col_r_next = rsp.quo; col_g_next = lvl;     col_b_next = 8'd0;
                            end
                            3'd2:
                            begin
                                col_r_next = 8'd0;    col_g_next = lvl;     col_b_next = t_reg;
                            end
                            3'd3:
                            begin
                                col_r_next = 8'd0;    col_g_next = rsp.quo; col_b_next = lvl;
                            end
                            3'd4:
                            begin
                                col_r_next = t_reg;   col_g_next = 8'd0;    col_b_next = lvl;
                            end
                            default:
                            begin
                                col_r_next = lvl;     col_g_next = 8'd0;    col_b_next = rsp.quo;
                            end
                        endcase
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, col_b_reg, col_r_reg, col_g_reg, led_reg};
                    out_last_next  = (led_reg == LED_W'(LED_TOTAL - 1));
                    out_fin_next   = fin_reg;
                    if (led_reg == LED_W'(LED_TOTAL - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        led_next   = led_reg + LED_W'(1);
                        state_next = ST_LED;
                        if (hrem_step >= 11'(HUE_SPAN))
                        begin
                            hrem_next = hrem_step - 11'(HUE_SPAN);
                            sec_next  = (sec_reg == 3'd5) ? 3'd0 : sec_reg + 3'd1;
                        end
                        else
                        begin
                            hrem_next = hrem_step;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            chase_position_reg <= '0;
            hue_phase_reg      <= '0;
            flash_ticks_reg    <= '0;
            halted_reg         <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            chase_position_reg <= chase_position_next;
            hue_phase_reg      <= hue_phase_next;
            flash_ticks_reg    <= flash_ticks_next;
            halted_reg         <= halted_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        led_reg      <= led_next;
        ch_reg       <= ch_next;
        fin_reg      <= fin_next;
        col_r_reg    <= col_r_next;
        col_g_reg    <= col_g_next;
        col_b_reg    <= col_b_next;
        p_reg        <= p_next;
        wc_reg       <= wc_next;
        num_reg      <= num_next;
        sec_reg      <= sec_next;
        hrem_reg     <= hrem_next;
        t_reg        <= t_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_fin_reg  <= out_fin_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_fin_reg;

    a_mdu_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.start && rsp.busy))
        else $error("multiply-divide unit started while busy");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[LED_W-1:0] == LED_W'(LED_TOTAL - 1)))
        else $error("tlast on a led other than the final one");

    a_led_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (led_reg <= LED_W'(LED_TOTAL - 1)))
        else $error("led index out of range");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT && kind_reg == K_RAINBOW) |->
            (hrem_reg < 11'(HUE_SPAN) && sec_reg <= 3'd5))
        else $error("hue sector or remainder out of range");

endmodule

`default_nettype wire

// File: tb/sv/led_strip_effect_generator_tb.sv
// led_strip_effect_generator_tb: self-checking bench that computes every led frame in a class
// and compares each led transaction of the block against it; depends on lseg_pkg and the rtl
// directed frames for every mode, stop and restart, then random phases with random stalls

module led_strip_effect_generator_tb;
    import lseg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES = 12;
    localparam int TICKS_PER_PHASE = 30;

    class led_frame_checker;
        typedef struct packed {
            logic [4:0] led_index;
            logic [7:0] green;
            logic [7:0] red;
            logic [7:0] blue;
            logic       last;
            logic       finished;
        } led_t;

        cfg_t        regs;
        logic [4:0]  chase_pos;
        logic [8:0]  hue_phase;
        logic [20:0] flash_ticks;
        logic        halted;
        led_t        leds_due[$];
        int          error_count;

        function new();
            regs.mode          = MODE_OFF;
            regs.red           = 8'd48;
            regs.green         = 8'd48;
            regs.blue          = 8'd48;
            regs.chase_width   = 5'd3;
            regs.flash_count   = 20'd0;
            regs.rainbow_level = 8'd63;
            chase_pos   = '0;
            hue_phase   = '0;
            flash_ticks = '0;
            halted      = 1'b0;
            error_count = 0;
        endfunction

        function void flag(string msg);
            error_count++;
            if (error_count <= 10)
                $display("%s", msg);
        endfunction

        function void write_reg(logic [2:0] idx, logic [19:0] val);
            case (idx)
                REG_MODE:          regs.mode = val[2:0];
                REG_RED:           regs.red = val[7:0];
                REG_GREEN:         regs.green = val[7:0];
                REG_BLUE:          regs.blue = val[7:0];
                REG_CHASE_WIDTH:   regs.chase_width = val[4:0];
                REG_FLASH_COUNT:   regs.flash_count = val;
                REG_RAINBOW_LEVEL: regs.rainbow_level = val[7:0];
                default:           ;
            endcase
        endfunction

        // one frame tick: update animation state and queue all led colors
        function void note_tick(bit restart, bit stop);
            int   r[LED_TOTAL];
            int   g[LED_TOTAL];
            int   b[LED_TOTAL];
            int   fin;
            int   w;
            int   k;
            int   num;
            int   den;
            int   h;
            int   span;
            int   rem;
            int   lvl;
            int   t;
            int   q;
            led_t led;
            if (restart)
            begin
                chase_pos   = '0;
                hue_phase   = '0;
                flash_ticks = '0;
                halted      = 1'b0;
            end
            if (stop)
                halted = 1'b1;
            for (int i = 0; i < LED_TOTAL; i++)
            begin
                r[i] = 0;
                g[i] = 0;
                b[i] = 0;
            end
            fin = 0;
            if (halted)
                fin = 1;
            else
            begin
                case (regs.mode)
                    MODE_SOLID, MODE_TIMING:
                        for (int i = 0; i < LED_TOTAL; i++)
                        begin
                            r[i] = int'((regs.mode == MODE_TIMING) ? TIMING_BYTE : regs.red);
                            g[i] = int'((regs.mode == MODE_TIMING) ? TIMING_BYTE : regs.green);
                            b[i] = int'((regs.mode == MODE_TIMING) ? TIMING_BYTE : regs.blue);
                        end
                    MODE_FLASH:
                        if (regs.flash_count != 0 &&
                            int'(flash_ticks) >= 2 * int'(regs.flash_count))
                            fin = 1;
                        else
                        begin
                            if (!flash_ticks[0])
                                for (int i = 0; i < LED_TOTAL; i++)
                                begin
                                    r[i] = int'(regs.red);
                                    g[i] = int'(regs.green);
                                    b[i] = int'(regs.blue);
                                end
                            flash_ticks = flash_ticks + 21'd1;
                        end
                    MODE_CHASE:
                    begin
                        w = int'(regs.chase_width);
                        if (w > LED_TOTAL)
                            w = LED_TOTAL;
                        den = w + 1;
                        for (int j = 0; j < w; j++)
                        begin
                            k = (int'(chase_pos) + LED_TOTAL - j) % LED_TOTAL;
                            num = w + 1 - j;
                            r[k] = int'(regs.red) * num / den;
                            g[k] = int'(regs.green) * num / den;
                            b[k] = int'(regs.blue) * num / den;
                        end
                        chase_pos = 5'((int'(chase_pos) + 1) % LED_TOTAL);
                    end
                    MODE_RAINBOW:
                    begin
                        span = 60 * LED_TOTAL;
                        lvl = int'(regs.rainbow_level);
                        for (int i = 0; i < LED_TOTAL; i++)
                        begin
                            h = (int'(hue_phase) * LED_TOTAL + i * 360) % (360 * LED_TOTAL);
                            rem = h % span;
                            t = lvl * rem / span;
                            q = lvl * (span - rem) / span;
                            case (h / span)
                                0:       begin r[i] = lvl; g[i] = t;   b[i] = 0;   end
                                1:       begin r[i] = q;   g[i] = lvl; b[i] = 0;   end
                                2:       begin r[i] = 0;   g[i] = lvl; b[i] = t;   end
                                3:       begin r[i] = 0;   g[i] = q;   b[i] = lvl; end
                                4:       begin r[i] = t;   g[i] = 0;   b[i] = lvl; end
                                default: begin r[i] = lvl; g[i] = 0;   b[i] = q;   end
                            endcase
                        end
                        hue_phase = 9'((int'(hue_phase) + 1) % 360);
                    end
                    default: ;
                endcase
            end
            for (int i = 0; i < LED_TOTAL; i++)
            begin
                led.led_index = i[4:0];
                led.green     = g[i][7:0];
                led.red       = r[i][7:0];
                led.blue      = b[i][7:0];
                led.last      = (i == LED_TOTAL - 1);
                led.finished  = fin[0];
                leds_due.push_back(led);
            end
        endfunction

        function void check_led(logic [31:0] data, logic tlast, logic tuser);
            led_t got;
            led_t want;
            got = {data[4:0], data[12:5], data[20:13], data[28:21], tlast, tuser};
            if (leds_due.size() == 0)
            begin
                flag({$sformatf("unexpected led transaction: idx %0d g %0d r %0d b %0d",
                                got.led_index, got.green, got.red, got.blue),
                      $sformatf(" last %0b fin %0b", got.last, got.finished)});
                return;
            end
            want = leds_due.pop_front();
            if (got.led_index !== want.led_index || got.green !== want.green ||
                got.red !== want.red || got.blue !== want.blue ||
                got.last !== want.last || got.finished !== want.finished)
                flag({$sformatf("led mismatch: expected idx %0d g %0d r %0d b %0d",
                                want.led_index, want.green, want.red, want.blue),
                      $sformatf(" last %0b fin %0b", want.last, want.finished),
                      $sformatf(", got idx %0d g %0d r %0d b %0d last %0b fin %0b",
                                got.led_index, got.green, got.red, got.blue,
                                got.last, got.finished)});
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_addr;
    logic [19:0] cfg_data;

    bit send_gaps;
    bit recv_stalls;

    led_frame_checker frames;

    always #6 clk = ~clk;

    led_strip_effect_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // cfg_valid is dropped after each write, which keeps back-to-back writes apart
    task automatic set_reg(logic [2:0] idx, logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        frames.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic frame_tick(bit restart, bit stop);
        int gap;
        gap = send_gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, stop, restart};
        do @(posedge clk); while (!s_tready);
        frames.note_tick(restart, stop);
    endtask

    // sender holds off until every led of every sent frame has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (frames.leds_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = recv_stalls ? $urandom_range(0, 13) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            frames.check_led(m_tdata, m_tlast, m_tuser);
        end
    end

    initial
    begin
        logic [2:0]  mode_pick;
        logic [19:0] count_pick;
        logic [4:0]  width_pick;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_addr    = '0;
        cfg_data    = '0;
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        frames      = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        frame_tick(0, 0);
        drain();
        set_reg(REG_MODE, {17'b0, MODE_SOLID});
        set_reg(REG_RED, 20'd255);
        set_reg(REG_GREEN, 20'd0);
        set_reg(REG_BLUE, 20'd1);
        frame_tick(0, 0);
        drain();
        set_reg(REG_MODE, {17'b0, MODE_TIMING});
        frame_tick(0, 0);
        drain();
        set_reg(REG_MODE, {17'b0, MODE_FLASH});
        set_reg(REG_FLASH_COUNT, 20'd1);
        frame_tick(1, 0);
        frame_tick(0, 0);
        frame_tick(0, 0);
        drain();
        set_reg(REG_MODE, {17'b0, MODE_CHASE});
        set_reg(REG_CHASE_WIDTH, 20'd0);
        frame_tick(0, 0);
        drain();
        set_reg(REG_CHASE_WIDTH, 20'd18);
        frame_tick(0, 0);
        drain();
        set_reg(REG_CHASE_WIDTH, 20'd31);
        frame_tick(0, 0);
        drain();
        set_reg(REG_CHASE_WIDTH, 20'd1);
        set_reg(REG_GREEN, 20'd255);
        set_reg(REG_BLUE, 20'd255);
        frame_tick(0, 0);
        frame_tick(0, 0);
        drain();
        set_reg(REG_MODE, {17'b0, MODE_RAINBOW});
        set_reg(REG_RAINBOW_LEVEL, 20'd255);
        frame_tick(0, 0);
        frame_tick(0, 0);
        drain();
        set_reg(REG_RAINBOW_LEVEL, 20'd0);
        frame_tick(0, 0);
        drain();
        set_reg(REG_MODE, {17'b0, MODE_SPARE_LO});
        frame_tick(0, 0);
        drain();
        set_reg(REG_MODE, {17'b0, MODE_SPARE_HI});
        frame_tick(0, 0);
        drain();
        set_reg(REG_MODE, {17'b0, MODE_CHASE});
        frame_tick(0, 1);
        frame_tick(0, 0);
        frame_tick(1, 1);
        frame_tick(1, 0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            send_gaps   = ($urandom_range(0, 3) != 0);
            recv_stalls = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0:       mode_pick = MODE_FLASH;
                1:       mode_pick = MODE_CHASE;
                2:       mode_pick = MODE_RAINBOW;
                default: mode_pick = 3'($urandom_range(0, 7));
            endcase
            case ($urandom_range(0, 7))
                0:       width_pick = 5'($urandom_range(0, 31));
                1:       width_pick = 5'd18;
                default: width_pick = 5'($urandom_range(1, 18));
            endcase
            case ($urandom_range(0, 7))
                0:       count_pick = 20'hFFFFF;
                1:       count_pick = 20'($urandom_range(0, 20'hFFFFF));
                default: count_pick = 20'($urandom_range(0, 12));
            endcase
            set_reg(REG_RED, {12'b0, pick_level()});
            set_reg(REG_GREEN, {12'b0, pick_level()});
            set_reg(REG_BLUE, {12'b0, pick_level()});
            set_reg(REG_CHASE_WIDTH, {15'b0, width_pick});
            set_reg(REG_FLASH_COUNT, count_pick);
            set_reg(REG_RAINBOW_LEVEL, {12'b0, pick_level()});
            set_reg(REG_MODE, {17'b0, mode_pick});
            for (int n = 0; n < TICKS_PER_PHASE; n++)
                frame_tick((n == 0) ? bit'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0),
                           ($urandom_range(0, 29) == 0));
        end
        drain();

        while (frames.leds_due.size() != 0)
        begin
            frames.flag($sformatf("led %0d of a frame never arrived",
                frames.leds_due[0].led_index));
            frames.leds_due.delete(0);
        end
        if (frames.error_count == 0)
            $display("led_strip_effect_generator_tb: clean");
        else
            $display("led_strip_effect_generator_tb: errors");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("led_strip_effect_generator_tb: errors");
        $finish;
    end

endmodule
